// ===== rtl/tree_postorder_index_generator_defines.svh =====
// ----------------------------------------------------------------------------
// tree postorder index generator assertion macros
// shared property forms for the walker checks
// ----------------------------------------------------------------------------
`ifndef TREE_POSTORDER_INDEX_GENERATOR_DEFINES_SVH
`define TREE_POSTORDER_INDEX_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TPIG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TPIG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tpig_pkg.sv =====
// ----------------------------------------------------------------------------
// tpig_pkg
// shared constants and result type of the postorder index generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpig_pkg;

  localparam int MAX_LEVELS_DEF = 16;
  localparam int OUT_W          = 16;
  localparam int CFG_W          = 5;
  localparam int LEVELS_RST     = 4;
  localparam int LEVELS_MIN     = 2;

  typedef struct packed {
    logic [OUT_W-1:0] post_position;
    logic [OUT_W-1:0] level_position;
    logic [OUT_W-1:0] parent_position;
    logic             is_root;
    logic             last;
  } rslt_t;

endpackage

// ===== rtl/tpig_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tpig_cmd_if
// input item channel: valid/ready with the restart flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpig_cmd_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/tpig_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tpig_rsp_if
// result item channel: valid/ready with node positions and flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpig_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tpig_pkg::OUT_W-1:0]  post_position;
  logic [tpig_pkg::OUT_W-1:0]  level_position;
  logic [tpig_pkg::OUT_W-1:0]  parent_position;
  logic                        is_root;
  logic                        last;

  modport source (output valid, output post_position, output level_position,
                  output parent_position, output is_root, output last, input ready);
  modport sink (input valid, input post_position, input level_position,
                input parent_position, input is_root, input last, output ready);
endinterface

// ===== rtl/tpig_walk.sv =====
// ----------------------------------------------------------------------------
// tpig_walk
// traversal state (counter, level, per-level side bits and offsets) and
// the single-step node computation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tree_postorder_index_generator_defines.svh"

module tpig_walk #(
  parameter int MAX_LEVELS = tpig_pkg::MAX_LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               step,
  input  logic                               restart,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]    levels,
  output tpig_pkg::rslt_t                    rslt
);
  import tpig_pkg::*;

  localparam int NW    = MAX_LEVELS;
  localparam int LVL_W = $clog2(MAX_LEVELS);
  localparam int LEN_W = $clog2(MAX_LEVELS + 1);

  logic [NW-1:0]    node_counter;
  logic [LVL_W-1:0] current_level;
  logic             side_bits [MAX_LEVELS];
  logic [NW-1:0]    level_offset [MAX_LEVELS];

  logic [LVL_W-1:0] j_eff;
  logic [NW-1:0]    k_eff;
  logic             right;
  logic [NW-1:0]    off;
  logic             root;
  logic [LEN_W-1:0] j_ext;
  logic [NW:0]      pow_l;
  logic [NW:0]      pow_lj;
  logic [NW:0]      start_j;
  logic [NW:0]      root_pos;
  logic [NW-1:0]    pow_j1;
  logic [NW-1:0]    lpos;
  logic [NW-1:0]    parent;

  // restart behaves as if the state had just been reloaded
  assign j_eff = restart ? '0 : current_level;
  assign k_eff = restart ? '0 : node_counter;
  assign right = restart ? 1'b0 : side_bits[j_eff];
  assign off   = restart ? '0 : level_offset[j_eff];
  assign j_ext = LEN_W'(j_eff);
  assign root  = (j_ext >= (levels - LEN_W'(1)));

  // level j starts at 2^l - 2^(l-j) in level order
  assign pow_l    = (NW+1)'(1) << levels;
  assign pow_lj   = (NW+1)'(1) << (levels - j_ext);
  assign start_j  = pow_l - pow_lj;
  assign root_pos = pow_l - (NW+1)'(2);
  assign pow_j1   = NW'(1) << (j_ext + LEN_W'(1));

  assign lpos   = root ? root_pos[NW-1:0] : (start_j[NW-1:0] + off);
  assign parent = root ? '0 : (right ? (k_eff + NW'(1)) : (k_eff + pow_j1));

  always_comb begin
    rslt.post_position   = OUT_W'(k_eff);
    rslt.level_position  = OUT_W'(lpos);
    rslt.parent_position = OUT_W'(parent);
    rslt.is_root         = root;
    rslt.last            = root;
  end

  always_ff @(posedge clk) begin
    if (rst || clear || (step && root)) begin
      node_counter  <= '0;
      current_level <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        side_bits[i]    <= 1'b0;
        level_offset[i] <= '0;
      end
    end else if (step) begin
      // the stepped level takes its update, restart clears all the others
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (LVL_W'(i) == j_eff) begin
          side_bits[i]    <= ~right;
          level_offset[i] <= off + NW'(1);
        end else if (restart) begin
          side_bits[i]    <= 1'b0;
          level_offset[i] <= '0;
        end
      end
      node_counter        <= k_eff + NW'(1);
      current_level       <= right ? (j_eff + LVL_W'(1)) : '0;
    end
  end

  `TPIG_ASSERT_NXT(a_root_wraps, step && root && !clear, (node_counter == '0) && (current_level == '0), "walk did not wrap after root")
  `TPIG_ASSERT_NXT(a_count_up, step && !root && !clear, node_counter == ($past(k_eff) + NW'(1)), "node counter did not advance")
  `TPIG_ASSERT_IMP(a_level_range, 1'b1, LEN_W'(current_level) < levels, "current level beyond root")

endmodule

// ===== rtl/tree_postorder_index_generator.sv =====
// ----------------------------------------------------------------------------
// tree_postorder_index_generator
// post-order walk of a complete binary tree, one node per item
// ----------------------------------------------------------------------------
// Each accepted item (restart flag) yields one result item: the next node of a
// post-order walk over a complete binary tree of 2^levels-1 nodes, with its
// post-order position, level-order index (leaves first), parent position and
// root/last flags. One item is taken per cycle while the result side does not
// stall; an item passes through an input register and an output register to
// its result, and the per-level side bits and offsets, updated as each item
// advances, set that rate. Writing levels (clamped to 2..MAX_LEVELS) restarts
// the walk from the first leaf; after the root the walk wraps by itself.
`timescale 1ns / 1ps

module tree_postorder_index_generator #(
  parameter int MAX_LEVELS = tpig_pkg::MAX_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tpig_pkg::CFG_W-1:0]  cfg_wr_data,
  tpig_cmd_if.sink                    cmd,
  tpig_rsp_if.source                  rsp
);
  import tpig_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEVELS + 1);

  logic [LEN_W-1:0] levels;
  logic             s1_valid;
  logic             s1_restart;
  logic             out_valid;
  rslt_t            out_data;
  rslt_t            rslt;
  logic             out_free;
  logic             advance;

  function automatic logic [LEN_W-1:0] clamp_levels(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (int'(v) < LEVELS_MIN) r = LEN_W'(LEVELS_MIN);
    else if (int'(v) > MAX_LEVELS) r = LEN_W'(MAX_LEVELS);
    else r = LEN_W'(v);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= clamp_levels(CFG_W'(LEVELS_RST));
    end else if (cfg_wr_en) begin
      levels <= clamp_levels(cfg_wr_data);
    end
  end

  assign out_free  = !out_valid || rsp.ready;
  assign advance   = s1_valid && out_free;
  assign cmd.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_restart <= cmd.restart;
    end
  end

  tpig_walk #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_wr_en),
    .step    (advance),
    .restart (s1_restart),
    .levels  (levels),
    .rslt    (rslt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rslt;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.post_position   = out_data.post_position;
  assign rsp.level_position  = out_data.level_position;
  assign rsp.parent_position = out_data.parent_position;
  assign rsp.is_root         = out_data.is_root;
  assign rsp.last            = out_data.last;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the post-order tree index generator: a directed
// walk of the reset tree, then random restart items over many tree sizes,
// every result compared field by field against a local walk predictor
// ----------------------------------------------------------------------------

module tb_top;
  import tpig_pkg::*;

  localparam int WALK_DEPTH  = MAX_LEVELS_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 145;

  typedef struct {
    bit    restart;
    bit    typed;
    rslt_t want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  tpig_cmd_if cmd_ch ();
  tpig_rsp_if rsp_ch ();

  tree_postorder_index_generator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch)
  );

  // walk predictor state
  logic [CFG_W-1:0] walk_levels;
  int unsigned      walk_count;
  int unsigned      walk_level;
  bit               walk_side [WALK_DEPTH];
  int unsigned      walk_cursor [WALK_DEPTH];

  rslt_t node_q [$];
  bit    cur_typed;
  rslt_t cur_want;
  int    err_cnt;
  int    items_sent;
  int    nodes_checked;
  int    walks_done;
  int    cfg_writes;
  bit    src_steady;
  bit    snk_steady;
  bit    hold_req;
  bit    holding;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_levels(logic [CFG_W-1:0] v);
    if (v < LEVELS_MIN) return LEVELS_MIN;
    if (v > WALK_DEPTH) return WALK_DEPTH;
    return int'(v);
  endfunction

  function automatic void reload_walk();
    int unsigned l;
    l = clamp_levels(walk_levels);
    walk_count = 0;
    walk_level = 0;
    for (int j = 0; j < WALK_DEPTH; j++) begin
      walk_side[j]   = 1'b0;
      walk_cursor[j] = (j < l) ? (1 << l) - (1 << (l - j)) : 0;
    end
  endfunction

  function automatic rslt_t next_node(bit restart);
    int unsigned l, j, k, lpos, parent;
    bit          right, root;
    rslt_t       r;
    l = clamp_levels(walk_levels);
    if (restart) reload_walk();
    j    = walk_level;
    k    = walk_count;
    root = (j >= l - 1);
    if (root) begin
      lpos   = (1 << l) - 2;
      parent = 0;
    end else begin
      right          = walk_side[j];
      lpos           = walk_cursor[j];
      // left child waits for its whole right sibling subtree
      parent         = right ? k + 1 : k + (1 << (j + 1));
      walk_cursor[j] = lpos + 1;
      walk_side[j]   = ~right;
      walk_count     = k + 1;
      walk_level     = right ? j + 1 : 0;
    end
    r.post_position   = OUT_W'(k);
    r.level_position  = OUT_W'(lpos);
    r.parent_position = OUT_W'(parent);
    r.is_root         = root;
    r.last            = root;
    if (root) reload_walk();
    return r;
  endfunction

  function automatic dir_row_t row(bit rs, bit typed = 1'b0, int unsigned post = 0,
                                   int unsigned lpos = 0, int unsigned par = 0,
                                   bit root = 1'b0);
    dir_row_t d;
    d.restart               = rs;
    d.typed                 = typed;
    d.want.post_position    = OUT_W'(post);
    d.want.level_position   = OUT_W'(lpos);
    d.want.parent_position  = OUT_W'(par);
    d.want.is_root          = root;
    d.want.last             = root;
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    if (src_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // item scoreboard and predictor update, all on the sampling edge
  always @(posedge clk) begin
    rslt_t got, want;
    if (!rst) begin
      if (cfg_wr_en) begin
        walk_levels = cfg_wr_data;
        reload_walk();
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        want = next_node(cmd_ch.restart);
        node_q.push_back(cur_typed ? cur_want : want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.post_position   = rsp_ch.post_position;
        got.level_position  = rsp_ch.level_position;
        got.parent_position = rsp_ch.parent_position;
        got.is_root         = rsp_ch.is_root;
        got.last            = rsp_ch.last;
        if (node_q.size() == 0) begin
          $error("result item with no item pending");
          err_cnt++;
        end else begin
          want = node_q.pop_front();
          nodes_checked++;
          if (got.is_root) walks_done++;
          if (got.post_position !== want.post_position) begin
            $error("post_position: expected %0d, got %0d",
                   want.post_position, got.post_position);
            err_cnt++;
          end
          if (got.level_position !== want.level_position) begin
            $error("level_position: expected %0d, got %0d",
                   want.level_position, got.level_position);
            err_cnt++;
          end
          if (got.parent_position !== want.parent_position) begin
            $error("parent_position: expected %0d, got %0d",
                   want.parent_position, got.parent_position);
            err_cnt++;
          end
          if (got.is_root !== want.is_root) begin
            $error("is_root: expected %0d, got %0d", want.is_root, got.is_root);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            err_cnt++;
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int r;
    rsp_ch.ready = 1'b0;
    holding      = 1'b0;
    forever begin
      if (hold_req) begin
        rsp_ch.ready = 1'b0;
        holding      = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding  = 1'b0;
        hold_req = 1'b0;
      end else if (snk_steady) begin
        rsp_ch.ready = 1'b1;
        @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rsp_ch.ready = 1'b1;
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end else if (r < 95) begin
          rsp_ch.ready = 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
        end else begin
          rsp_ch.ready = 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  // stall watchdog
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(bit restart, bit typed, rslt_t want, bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid   = 1'b1;
    cmd_ch.restart = restart;
    cur_typed      = typed;
    cur_want       = want;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    while (node_q.size() != 0) @(negedge clk);
    // two register stages between item and result
    repeat (4) @(negedge clk);
  endtask

  task automatic write_levels(logic [CFG_W-1:0] v);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cfg_writes++;
  endtask

  initial begin
    dir_row_t         dir_rows [$];
    logic [CFG_W-1:0] phase_levels [$];
    int               pct;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.restart = 1'b0;
    cur_typed      = 1'b0;
    cur_want       = '0;
    src_steady     = 1'b0;
    snk_steady     = 1'b0;
    hold_req       = 1'b0;
    walk_levels    = CFG_W'(LEVELS_RST);
    reload_walk();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset tree has four levels, fifteen nodes
    dir_rows.push_back(row(1'b0, 1'b1, 0, 0, 2));        // first leaf after reset
    repeat (13) dir_rows.push_back(row(1'b0));
    dir_rows.push_back(row(1'b0, 1'b1, 14, 14, 0, 1'b1)); // root ends the walk
    dir_rows.push_back(row(1'b0, 1'b1, 0, 0, 2));        // wrap to first leaf
    dir_rows.push_back(row(1'b0));
    dir_rows.push_back(row(1'b0));
    dir_rows.push_back(row(1'b1, 1'b1, 0, 0, 2));        // restart mid-walk
    dir_rows.push_back(row(1'b1, 1'b1, 0, 0, 2));        // back-to-back restart
    dir_rows.push_back(row(1'b0));
    foreach (dir_rows[i])
      send_item(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    cmd_ch.valid = 1'b0;

    // smallest tree, clamped low values, largest and clamped high values
    phase_levels = '{5'd2, 5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd3, 5'd5, 5'd6, 5'd4};
    repeat (4) phase_levels.push_back(CFG_W'($urandom_range(0, 31)));

    foreach (phase_levels[p]) begin
      drain();
      write_levels(phase_levels[p]);
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: pct = 0;
        1: pct = 2;
        default: pct = 8;
      endcase
      if (p == 4) begin
        hold_req = 1'b1;
        wait (holding);
        repeat (40) send_item($urandom_range(0, 99) < pct, 1'b0, '0, 1'b1);
      end
      repeat (PHASE_ITEMS) send_item($urandom_range(0, 99) < pct, 1'b0, '0, 1'b0);
      cmd_ch.valid = 1'b0;
    end
    src_steady = 1'b0;
    snk_steady = 1'b0;

    drain();
    repeat (8) @(negedge clk);
    if (node_q.size() != 0) begin
      $error("%0d expected results never arrived", node_q.size());
      err_cnt++;
    end
    $display("run covered %0d tree-size writes incl. clamped extremes, %0d items sent",
             cfg_writes, items_sent);
    $display("%0d results checked, %0d walks reached the root", nodes_checked, walks_done);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
